// ===== hw/rtl/vfrq_pkg.sv =====
// ----------------------------------------------------------------------------
// vfrq_pkg
// Shared types and constants of the variable frame ring queue: operation
// codes, status codes, frame header size and default sizes.
// ----------------------------------------------------------------------------
package vfrq_pkg;

	localparam int RING_BYTES_DEF = 4096;
	localparam int MAX_READ_DEF   = 64;
	localparam int HDR_BYTES      = 8;
	localparam int CNT_MAX        = 4095;
	localparam int CNT_W          = 12;
	localparam int RUN_W          = 7;

	typedef enum logic [2:0] {
		OP_APPEND    = 3'd0,
		OP_READ_CMD  = 3'd1,
		OP_READ_DATA = 3'd2,
		OP_DATA_LEN  = 3'd3,
		OP_CONSUME   = 3'd4,
		OP_DROP      = 3'd5,
		OP_CLEAR     = 3'd6,
		OP_NONE      = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_DUP   = 2'd3
	} status_t;

endpackage

// ===== hw/rtl/vfrq_ram.sv =====
// ----------------------------------------------------------------------------
// vfrq_ram
// Byte ring storage: one write port and one read port with registered
// read data.
// ----------------------------------------------------------------------------
module vfrq_ram #(
	parameter int AW = 12
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);
	logic [7:0] mem [0:(1 << AW) - 1];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/variable_frame_ring_queue.sv =====
// ----------------------------------------------------------------------------
// variable_frame_ring_queue
// Byte ring of variable-length frames (8-byte header, command part, data
// part) with append, head read, length, consume, drop and clear.
// ----------------------------------------------------------------------------
// Channel | Handshake           | Payload
// in      | in_valid / in_stall | op, byte_value, is_data, last_byte,
//         |                     | hold_repeat, offset, count
// out     | out_valid/out_stall | byte_value_res, count_res, status, last
//
// A byte that does not end a frame is written to the ring as it is accepted.
// A frame commit writes the 8-byte header; with hold_repeat set, it first
// runs a duplicate search, which walks the queued frames through the single
// memory read port and compares their command bytes. Head operations read
// the 8-byte header; reads then deliver bytes one at a time, and consume
// writes back 4 header bytes. RING_BYTES must be a power of two. Reset
// clears the pointers and control state but not the ring; the ring needs no
// clearing pass. A stalled output holds the sequencer in place.
// ----------------------------------------------------------------------------
module variable_frame_ring_queue #(
	parameter int RING_BYTES = vfrq_pkg::RING_BYTES_DEF,
	parameter int MAX_READ   = vfrq_pkg::MAX_READ_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [2:0]               op,
	input  logic [7:0]               byte_value,
	input  logic                     is_data,
	input  logic                     last_byte,
	input  logic                     hold_repeat,
	input  logic [11:0]              offset,
	input  logic [11:0]              count,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [7:0]               byte_value_res,
	output logic [vfrq_pkg::CNT_W-1:0] count_res,
	output logic [1:0]               status,
	output logic                     last
);
	import vfrq_pkg::*;

	localparam int AW = $clog2(RING_BYTES);
	localparam int XW = ((AW > CNT_W) ? AW : CNT_W) + 1;

	typedef enum logic [12:0] {
		S_IDLE    = 13'b0000000000001,
		S_DECIDE  = 13'b0000000000010,
		S_FETCH   = 13'b0000000000100,
		S_EXEC    = 13'b0000000001000,
		S_DS_TOP  = 13'b0000000010000,
		S_DS_EVAL = 13'b0000000100000,
		S_DS_A    = 13'b0000001000000,
		S_DS_B    = 13'b0000010000000,
		S_DS_C    = 13'b0000100000000,
		S_WR      = 13'b0001000000000,
		S_RD_A    = 13'b0010000000000,
		S_RD_B    = 13'b0100000000000,
		S_EMIT    = 13'b1000000000000
	} state_t;

	function automatic logic [CNT_W-1:0] sat_cnt(input logic [XW-1:0] v);
		return (v > XW'(CNT_MAX)) ? CNT_W'(CNT_MAX) : v[CNT_W-1:0];
	endfunction

	state_t            state_q;
	logic [AW-1:0]     rp_q, wp_q, build_q, cmdlen_q, pos_q, base_q, from_q, ci_q;
	logic              ovf_q, hold_q, fetch_dup_q;
	logic [3:0]        idx_q;
	logic [63:0]       hdr_q, wbuf_q;
	logic [2:0]        wcnt_q, wend_q;
	logic [7:0]        a_q;
	logic [RUN_W-1:0]  ri_q, n_q;
	op_t               op_q;
	logic [11:0]       off_q, cnt_q;
	logic [CNT_W-1:0]  res_count_q;
	status_t           res_status_q;

	logic              out_valid_q, last_q;
	logic [7:0]        out_byte_q;
	logic [CNT_W-1:0]  out_count_q;
	logic [1:0]        out_status_q;

	logic              acc, ofree, fits, emit_now;
	logic              mem_we, mem_re;
	logic [AW-1:0]     mem_wa, mem_ra;
	logic [7:0]        mem_wd, rd;
	logic [AW-1:0]     used, fre, nxt_c, ds_c, len_c, body_c, run_from_c, nds_c;
	logic [XW-1:0]     off_x, len_x, avail_c, o_c, left_c, del_c;
	logic [RUN_W-1:0]  lim_c, run_n_c;
	logic              run_none_c;

	assign acc      = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign ofree    = !out_valid_q || !out_stall;
	assign emit_now = ofree && (state_q == S_RD_B || state_q == S_EMIT);

	// Free space check for the next appended byte, header included.
	assign used = wp_q - rp_q;
	assign fre  = AW'(RING_BYTES - 1) - used;
	assign fits = ({1'b0, build_q} + (AW+1)'(HDR_BYTES + 1)) <= {1'b0, fre};

	assign nxt_c  = hdr_q[32 +: AW];
	assign ds_c   = hdr_q[0 +: AW];
	assign len_c  = nxt_c - ds_c;
	assign body_c = nxt_c - (pos_q + AW'(HDR_BYTES));
	assign off_x  = XW'(off_q);
	assign len_x  = XW'(len_c);

	always_comb begin
		if (op_q == OP_READ_CMD) begin
			avail_c    = XW'(ds_c - (rp_q + AW'(HDR_BYTES)));
			run_from_c = rp_q + AW'(HDR_BYTES);
		end else begin
			avail_c    = (off_x >= len_x) ? '0 : (len_x - off_x);
			run_from_c = ds_c + off_x[AW-1:0];
		end
		lim_c   = (cnt_q == '0 || cnt_q > 12'(MAX_READ)) ? RUN_W'(MAX_READ) : cnt_q[RUN_W-1:0];
		run_n_c = (avail_c < XW'(lim_c)) ? avail_c[RUN_W-1:0] : lim_c;
		run_none_c = (run_n_c == '0);
		o_c    = (off_x > len_x) ? len_x : off_x;
		left_c = len_x - o_c;
		if (cnt_q == '0) begin
			del_c = len_x;
			nds_c = nxt_c;
		end else begin
			del_c = (XW'(cnt_q) < left_c) ? XW'(cnt_q) : left_c;
			nds_c = ds_c + o_c[AW-1:0] + del_c[AW-1:0];
		end
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = '0;
		mem_wd = '0;
		mem_re = 1'b0;
		mem_ra = '0;
		case (state_q)
			S_IDLE: begin
				if (acc && op == OP_APPEND && !ovf_q && fits) begin
					mem_we = 1'b1;
					mem_wa = wp_q + AW'(HDR_BYTES) + build_q;
					mem_wd = byte_value;
				end
			end
			S_WR: begin
				mem_we = 1'b1;
				mem_wa = base_q + AW'(wcnt_q);
				mem_wd = wbuf_q[63:56];
			end
			S_FETCH: begin
				mem_re = (idx_q < 4'd8);
				mem_ra = base_q + AW'(idx_q);
			end
			S_DS_A: begin
				mem_re = 1'b1;
				mem_ra = pos_q + AW'(HDR_BYTES) + ci_q;
			end
			S_DS_B: begin
				mem_re = 1'b1;
				mem_ra = wp_q + AW'(HDR_BYTES) + ci_q;
			end
			S_RD_A: begin
				mem_re = 1'b1;
				mem_ra = from_q + AW'(ri_q);
			end
			default: begin
			end
		endcase
	end

	vfrq_ram #(.AW(AW)) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_wa),
		.wdata (mem_wd),
		.re    (mem_re),
		.raddr (mem_ra),
		.rdata (rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rp_q        <= '0;
			wp_q        <= '0;
			build_q     <= '0;
			cmdlen_q    <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_now) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						op_q  <= op_t'(op);
						off_q <= offset;
						cnt_q <= count;
						case (op)
							OP_APPEND: begin
								if (!ovf_q) begin
									if (fits) begin
										build_q <= build_q + 1'b1;
										if (!is_data && cmdlen_q == build_q) begin
											cmdlen_q <= cmdlen_q + 1'b1;
										end
									end else begin
										ovf_q <= 1'b1;
									end
								end
								if (last_byte) begin
									hold_q  <= hold_repeat;
									state_q <= S_DECIDE;
								end
							end
							OP_CLEAR: begin
								rp_q         <= '0;
								wp_q         <= '0;
								build_q      <= '0;
								cmdlen_q     <= '0;
								ovf_q        <= 1'b0;
								res_count_q  <= '0;
								res_status_q <= ST_OK;
								state_q      <= S_EMIT;
							end
							OP_NONE: begin
							end
							default: begin
								if (rp_q == wp_q) begin
									res_count_q  <= '0;
									res_status_q <= ST_EMPTY;
									state_q      <= S_EMIT;
								end else begin
									base_q      <= rp_q;
									idx_q       <= '0;
									fetch_dup_q <= 1'b0;
									state_q     <= S_FETCH;
								end
							end
						endcase
					end
				end
				S_DECIDE, S_DS_TOP: begin
					if (state_q == S_DECIDE && ovf_q) begin
						res_count_q  <= '0;
						res_status_q <= ST_FULL;
						build_q      <= '0;
						cmdlen_q     <= '0;
						ovf_q        <= 1'b0;
						state_q      <= S_EMIT;
					end else if (state_q == S_DECIDE && hold_q && rp_q != wp_q) begin
						pos_q   <= rp_q;
						state_q <= S_DS_TOP;
					end else if (state_q == S_DS_TOP && pos_q != wp_q) begin
						base_q      <= pos_q;
						idx_q       <= '0;
						fetch_dup_q <= 1'b1;
						state_q     <= S_FETCH;
					end else begin
						// Commit: advance the write pointer to publish the frame, then write the header.
						wbuf_q <= {32'(wp_q + AW'(HDR_BYTES) + build_q),
							32'(wp_q + AW'(HDR_BYTES) + cmdlen_q)};
						base_q       <= wp_q;
						wp_q         <= wp_q + AW'(HDR_BYTES) + build_q;
						wcnt_q       <= '0;
						wend_q       <= 3'd7;
						res_count_q  <= sat_cnt(XW'(build_q));
						res_status_q <= ST_OK;
						build_q      <= '0;
						cmdlen_q     <= '0;
						ovf_q        <= 1'b0;
						state_q      <= S_WR;
					end
				end
				S_FETCH: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q != '0) begin
						hdr_q <= {hdr_q[55:0], rd};
					end
					if (idx_q == 4'd8) begin
						state_q <= fetch_dup_q ? S_DS_EVAL : S_EXEC;
					end
				end
				S_DS_EVAL: begin
					if (body_c >= cmdlen_q) begin
						ci_q    <= '0;
						state_q <= S_DS_A;
					end else begin
						pos_q   <= nxt_c;
						state_q <= S_DS_TOP;
					end
				end
				S_DS_A: begin
					if (ci_q == cmdlen_q) begin
						res_count_q  <= '0;
						res_status_q <= ST_DUP;
						build_q      <= '0;
						cmdlen_q     <= '0;
						ovf_q        <= 1'b0;
						state_q      <= S_EMIT;
					end else begin
						state_q <= S_DS_B;
					end
				end
				S_DS_B: begin
					a_q     <= rd;
					state_q <= S_DS_C;
				end
				S_DS_C: begin
					if (rd == a_q) begin
						ci_q    <= ci_q + 1'b1;
						state_q <= S_DS_A;
					end else begin
						pos_q   <= nxt_c;
						state_q <= S_DS_TOP;
					end
				end
				S_WR: begin
					wbuf_q <= {wbuf_q[55:0], 8'h00};
					wcnt_q <= wcnt_q + 1'b1;
					if (wcnt_q == wend_q) begin
						state_q <= S_EMIT;
					end
				end
				S_EXEC: begin
					res_status_q <= ST_OK;
					case (op_q)
						OP_READ_CMD, OP_READ_DATA: begin
							res_count_q <= '0;
							if (run_none_c) begin
								state_q <= S_EMIT;
							end else begin
								from_q  <= run_from_c;
								n_q     <= run_n_c;
								ri_q    <= '0;
								state_q <= S_RD_A;
							end
						end
						OP_DATA_LEN: begin
							res_count_q <= sat_cnt(len_x);
							state_q     <= S_EMIT;
						end
						OP_CONSUME: begin
							wbuf_q      <= {32'(nds_c), 32'h0};
							base_q      <= rp_q + AW'(4);
							wcnt_q      <= '0;
							wend_q      <= 3'd3;
							res_count_q <= sat_cnt(del_c);
							state_q     <= S_WR;
						end
						OP_DROP: begin
							res_count_q <= '0;
							rp_q        <= nxt_c;
							state_q     <= S_EMIT;
						end
						default: begin
							res_count_q <= '0;
							state_q     <= S_EMIT;
						end
					endcase
				end
				S_RD_A: begin
					state_q <= S_RD_B;
				end
				S_RD_B: begin
					if (ofree) begin
						out_byte_q   <= rd;
						out_count_q  <= CNT_W'(ri_q + 1'b1);
						out_status_q <= ST_OK;
						last_q       <= (ri_q + 1'b1 == n_q);
						if (ri_q + 1'b1 == n_q) begin
							state_q <= S_IDLE;
						end else begin
							ri_q    <= ri_q + 1'b1;
							state_q <= S_RD_A;
						end
					end
				end
				S_EMIT: begin
					if (ofree) begin
						out_byte_q   <= '0;
						out_count_q  <= res_count_q;
						out_status_q <= res_status_q;
						last_q       <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign byte_value_res = out_byte_q;
	assign count_res      = out_count_q;
	assign status         = out_status_q;
	assign last           = last_q;

	a_run_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD_B) |-> (ri_q < n_q))
		else $error("read run index past its length");

	a_clear_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && op == OP_CLEAR) |=> (rp_q == '0 && wp_q == '0 && state_q == S_EMIT))
		else $error("clear did not reset the ring pointers");

	a_search_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FETCH && fetch_dup_q) |-> (pos_q != wp_q))
		else $error("duplicate search fetched past the queue tail");

endmodule
